>>> rtl/sdf_arc_expander_unit_defines.svh
// assertion macros shared by the sdf arc expander rtl
// depends on clk_i and rst_ni being visible in the including module
`ifndef SDF_ARC_EXPANDER_UNIT_DEFINES_SVH
`define SDF_ARC_EXPANDER_UNIT_DEFINES_SVH

// checked on every edge once reset is released
`define SAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define SAE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/sae_pkg.sv
// types, widths and constants of the sdf arc expander
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sae_pkg;

  localparam int unsigned MAX_REPS_DEF = 32;
  localparam int unsigned MAX_RATE_DEF = 255;
  localparam int unsigned RUN_LIMIT    = 64;

  localparam int unsigned RATE_W  = 8;
  localparam int unsigned REPS_W  = 6;
  localparam int unsigned DLYIN_W = 16;
  localparam int unsigned TOT_W   = RATE_W + REPS_W;
  localparam int unsigned DLY_W   = 17;
  localparam int unsigned KCNT_W  = $clog2(RUN_LIMIT);
  localparam int unsigned DIV_STEPS = DLYIN_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [RATE_W-1:0]  produce_rate;
    logic [RATE_W-1:0]  consume_rate;
    logic [DLYIN_W-1:0] initial_delays;
    logic [REPS_W-1:0]  src_reps;
    logic [REPS_W-1:0]  dest_reps;
  } sae_in_t;

  typedef struct packed {
    logic [REPS_W-1:0] src_fire_idx;
    logic [REPS_W-1:0] dst_fire_idx;
    logic [RATE_W-1:0] src_first_sample;
    logic [RATE_W-1:0] dest_first_sample;
    logic [RATE_W-1:0] token_count;
    logic [DLY_W-1:0]  arc_delay;
    logic              last;
    logic              rate_error;
  } sae_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel;
    logic take_q1;
    logic take_q2;
    logic emit_err;
    logic step;
  } sae_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_operand;
    logic div_done;
    logic out_free;
    logic arc_final;
  } sae_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ERR,
    ST_DIV1,
    ST_START2,
    ST_DIV2,
    ST_WALK
  } sae_state_e;

  localparam logic DIV_SEL_DELAY = 1'b0;
  localparam logic DIV_SEL_OFFS  = 1'b1;

endpackage

`default_nettype wire

>>> rtl/sdf_arc_expander_unit.sv
// Expands one multirate dataflow arc (producer and consumer rates, initial
// delays, repetition counts) into its run of homogeneous arcs, one output beat
// per arc, with last on the final beat and rate_error on a rate overrun, a run
// that reaches 64 arcs with tokens left, or a bad operand (single error beat).
// One input beat is handled at a time: after acceptance, the check state
// tests the operands and starts the shared radix-2 divider, which splits
// the delay by the period token count; the restart state starts it again
// to split the offset by the consumer rate; arcs then leave at one per
// cycle while the output side takes them, and output stalls hold the walk.
// A run has at most 64 arcs. A bad operand goes from the check state to the
// error state, which registers its single beat once the output is free.
// in_ready_o rises again as soon as the last beat is registered, so the
// next input beat can then be taken.
// Depends on sae_pkg, sae_ctrl, sae_datapath and sae_divider.
`timescale 1ns / 1ps
`default_nettype none

module sdf_arc_expander_unit
  import sae_pkg::*;
#(
  parameter int unsigned MAX_REPS = MAX_REPS_DEF,  // largest accepted rep count
  parameter int unsigned MAX_RATE = MAX_RATE_DEF   // largest accepted rate
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  // input beat: one multirate arc
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire sae_in_t in_data_i,
  // output beat: one homogeneous arc
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output sae_out_t     out_data_o
);

  // command and status between sequencer and datapath
  sae_cmd_t cmd;
  sae_sts_t sts;

  // sequencer: operand check, then an error beat or two divisions and the arc walk
  sae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: operand capture, divider, walk registers, output register
  sae_datapath #(
    .MAX_REPS (MAX_REPS),
    .MAX_RATE (MAX_RATE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> rtl/sae_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on sae_pkg
`timescale 1ns / 1ps
`default_nettype none

module sae_divider
  import sae_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [DLYIN_W-1:0] dividend_i,
  input  wire logic [TOT_W-1:0]   divisor_i,
  output logic                    done_o,
  output logic [DLYIN_W-1:0]      quot_o,
  output logic [TOT_W-1:0]        rem_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DLYIN_W-1:0]   quo_q, quo_d;
  logic [TOT_W-1:0]     rem_q, rem_d;
  logic [TOT_W-1:0]     dvs_q, dvs_d;
  logic [TOT_W:0]       trial;
  logic                 ge;

  assign trial = {rem_q, quo_q[DLYIN_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DLYIN_W-2:0], ge};
      rem_d = ge ? TOT_W'(trial - {1'b0, dvs_q}) : trial[TOT_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> rtl/sae_datapath.sv
// operand registers, arc walk state and output register
// depends on sae_pkg, sae_divider and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "sdf_arc_expander_unit_defines.svh"

module sae_datapath
  import sae_pkg::*;
#(
  parameter int unsigned MAX_REPS = MAX_REPS_DEF,
  parameter int unsigned MAX_RATE = MAX_RATE_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire sae_in_t  in_data_i,
  input  wire sae_cmd_t cmd_i,
  output sae_sts_t      sts_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output sae_out_t      out_data_o
);

  // captured operands
  logic [RATE_W-1:0]  p_q, q_q;
  logic [DLYIN_W-1:0] d_q;
  logic [REPS_W-1:0]  vs_q, vd_q;
  logic [TOT_W-1:0]   total_q;
  logic               bad_q;
  logic               bad_in;

  // walk state
  logic [REPS_W-1:0]       si_q, di_q;
  logic [RATE_W-1:0]       ss_q, ds_q;
  logic [DLY_W-1:0]        dly_q;
  logic signed [TOT_W:0]   remain_q;
  logic [KCNT_W-1:0]       k_q;

  // output register
  logic     out_valid_q;
  sae_out_t out_q;

  // divider
  logic [DLYIN_W-1:0] div_dividend, div_quot;
  logic [TOT_W-1:0]   div_divisor, div_rem;
  logic               div_done;

  // next arc
  logic [RATE_W-1:0]     sleft, dleft, cnt;
  logic [RATE_W-1:0]     ss_n, ds_n;
  logic [REPS_W-1:0]     si_inc, di_inc, si_n, di_n;
  logic                  si_adv, di_adv;
  logic [DLY_W-1:0]      dly_n;
  logic signed [TOT_W:0] remain_n;
  logic                  neg, zero, limit, final_arc;
  sae_out_t              arc_beat, err_beat;

  assign bad_in = (in_data_i.produce_rate == '0) || (in_data_i.consume_rate == '0) ||
                  (in_data_i.src_reps == '0) || (in_data_i.dest_reps == '0) ||
                  (7'(in_data_i.src_reps) > 7'(MAX_REPS)) ||
                  (7'(in_data_i.dest_reps) > 7'(MAX_REPS)) ||
                  (17'(in_data_i.produce_rate) > 17'(MAX_RATE)) ||
                  (17'(in_data_i.consume_rate) > 17'(MAX_RATE));

  assign div_dividend = (cmd_i.div_sel == DIV_SEL_OFFS) ? DLYIN_W'(div_rem) : d_q;
  assign div_divisor  = (cmd_i.div_sel == DIV_SEL_OFFS) ? TOT_W'(q_q) : total_q;

  sae_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    sleft  = p_q - ss_q;
    dleft  = q_q - ds_q;
    si_adv = 1'b0;
    di_adv = 1'b0;
    if (sleft == dleft) begin
      cnt    = sleft + 1'b1;
      ss_n   = RATE_W'(1);
      ds_n   = RATE_W'(1);
      si_adv = 1'b1;
      di_adv = 1'b1;
    end else if (sleft < dleft) begin
      cnt    = sleft + 1'b1;
      ss_n   = RATE_W'(1);
      ds_n   = ds_q + cnt;
      si_adv = 1'b1;
    end else begin
      cnt    = dleft + 1'b1;
      ds_n   = RATE_W'(1);
      ss_n   = ss_q + cnt;
      di_adv = 1'b1;
    end
    si_inc = si_adv ? si_q + 1'b1 : si_q;
    di_inc = di_adv ? di_q + 1'b1 : di_q;
    si_n   = (si_inc > vs_q) ? REPS_W'(1) : si_inc;
    di_n   = (di_inc > vd_q) ? REPS_W'(1) : di_inc;
    dly_n  = (di_inc > vd_q) ? dly_q + 1'b1 : dly_q;

    remain_n  = remain_q - $signed({{(TOT_W + 1 - RATE_W){1'b0}}, cnt});
    neg       = remain_n < 0;
    zero      = remain_n == 0;
    limit     = k_q == KCNT_W'(RUN_LIMIT - 1);
    final_arc = neg || zero || limit;

    arc_beat.src_fire_idx      = si_q;
    arc_beat.dst_fire_idx      = di_q;
    arc_beat.src_first_sample  = ss_q;
    arc_beat.dest_first_sample = ds_q;
    arc_beat.token_count       = cnt;
    arc_beat.arc_delay         = dly_q;
    arc_beat.last              = final_arc;
    arc_beat.rate_error        = neg || (!zero && limit);

    err_beat            = '0;
    err_beat.last       = 1'b1;
    err_beat.rate_error = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q     <= in_data_i.produce_rate;
      q_q     <= in_data_i.consume_rate;
      d_q     <= in_data_i.initial_delays;
      vs_q    <= in_data_i.src_reps;
      vd_q    <= in_data_i.dest_reps;
      total_q <= TOT_W'(in_data_i.dest_reps) * TOT_W'(in_data_i.consume_rate);
      bad_q   <= bad_in;
    end
    if (cmd_i.take_q1) begin
      dly_q <= DLY_W'(div_quot);
    end
    if (cmd_i.take_q2) begin
      di_q     <= REPS_W'(div_quot) + 1'b1;
      ds_q     <= RATE_W'(div_rem) + 1'b1;
      si_q     <= REPS_W'(1);
      ss_q     <= RATE_W'(1);
      remain_q <= $signed({1'b0, total_q});
      k_q      <= '0;
    end
    if (cmd_i.step) begin
      si_q     <= si_n;
      di_q     <= di_n;
      ss_q     <= ss_n;
      ds_q     <= ds_n;
      dly_q    <= dly_n;
      remain_q <= remain_n;
      k_q      <= k_q + 1'b1;
    end
    if (cmd_i.step) begin
      out_q <= arc_beat;
    end else if (cmd_i.emit_err) begin
      out_q <= err_beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step || cmd_i.emit_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.bad_operand = bad_q;
  assign sts_o.div_done    = div_done;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.arc_final   = final_arc;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SAE_ASSERT(a_err_only_on_last, out_valid_q && !out_q.last |-> !out_q.rate_error, "error flag on non-final arc")
  `SAE_ASSERT(a_arc_has_tokens, out_valid_q && !out_q.last |-> out_q.token_count != '0, "empty arc mid-run")
  `SAE_ASSERT(a_no_overwrite, (cmd_i.step || cmd_i.emit_err) |-> (!out_valid_q || out_ready_i), "output beat overwritten")

endmodule

`default_nettype wire

>>> rtl/sae_ctrl.sv
// sequencing state machine of the arc expander
// depends on sae_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "sdf_arc_expander_unit_defines.svh"

module sae_ctrl
  import sae_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire sae_sts_t sts_i,
  output sae_cmd_t      cmd_o
);

  sae_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = DIV_SEL_DELAY;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.bad_operand) begin
          state_d = ST_ERR;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV1;
        end
      end
      ST_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_DIV1: begin
        if (sts_i.div_done) begin
          cmd_o.take_q1 = 1'b1;
          state_d       = ST_START2;
        end
      end
      ST_START2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SEL_OFFS;
        state_d         = ST_DIV2;
      end
      ST_DIV2: begin
        if (sts_i.div_done) begin
          cmd_o.take_q2 = 1'b1;
          state_d       = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.arc_final) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `SAE_ASSERT(a_step_needs_room, cmd_o.step |-> sts_i.out_free, "arc stepped into a full output")
  `SAE_ASSERT(a_err_needs_bad, cmd_o.emit_err |-> sts_i.bad_operand, "error beat without bad operand")
  `SAE_ASSERT(a_busy_after_load, cmd_o.load |=> !in_ready_o, "new beat taken mid-run")
  `SAE_ASSERT_ALWAYS(a_start_no_early_done, rst_ni && cmd_o.div_start |=> !sts_i.div_done, "divider done too early")

endmodule

`default_nettype wire
